/* rtl/rfo_pkg.sv */
`timescale 1ns / 1ps

package rfo_pkg;

    localparam int DATA_BITS  = 16;
    localparam int COUNT_BITS = 6;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_FORCE = 2'd1,
        KIND_DEQ   = 2'd2,
        KIND_FLUSH = 2'd3
    } rfo_kind_t;

    typedef struct packed {
        rfo_kind_t              kind;
        logic [DATA_BITS-1:0]   item_data;
    } rfo_cmd_t;

    typedef struct packed {
        logic                   accepted;
        logic                   out_valid;
        logic [DATA_BITS-1:0]   out_data;
        logic [COUNT_BITS-1:0]  fill_count;
    } rfo_result_t;

endpackage

/* rtl/rfo_cell.sv */
`timescale 1ns / 1ps

module rfo_cell #(
    parameter int ITEM_BITS = 16
) (
    input  logic                 clk,
    input  logic                 shift,
    input  logic                 load,
    input  logic [ITEM_BITS-1:0] fresh,
    input  logic [ITEM_BITS-1:0] upstream,
    output logic [ITEM_BITS-1:0] word
);

    logic [ITEM_BITS-1:0] word_reg;
    logic [ITEM_BITS-1:0] word_next;

    // load wins: a forced transfer into a full row shifts and loads the tail cell
    always_comb
    begin
        if (load)
        begin
            word_next = fresh;
        end
        else if (shift)
        begin
            word_next = upstream;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/ring_fifo_with_overwrite.sv */
`timescale 1ns / 1ps

// Ring FIFO with overwrite of the oldest entry, built as a row of DEPTH cells with
// the oldest item always in the first cell. One operation is taken every cycle
// (busy stays low); its result appears on result with done high in the cycle after
// start, and must be taken in that cycle since there is no back-pressure.
// The rate is set by the cell row: every cell loads, shifts toward the head or
// holds together, so a dequeue or a forced overwrite moves the whole row
// at once. Flush only clears the fill count; stale words are never read.
module ring_fifo_with_overwrite #(
    parameter int DEPTH     = 32,
    parameter int ITEM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rfo_pkg::rfo_cmd_t   cmd,
    output logic                done,
    output rfo_pkg::rfo_result_t result
);

    import rfo_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic                  accept;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic                  full;
    logic                  empty;
    logic                  shift;
    logic                  load_en;
    logic [IDX_W-1:0]      load_idx;
    logic                  acc;
    logic                  vld;
    logic [ITEM_BITS-1:0]  fresh;
    logic [ITEM_BITS-1:0]  cell_word [DEPTH];
    logic                  done_reg;
    rfo_result_t           result_reg;
    rfo_result_t           result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (fill_reg == FILL_W'(DEPTH));
    assign empty  = (fill_reg == '0);
    assign fresh  = ITEM_BITS'(cmd.item_data);

    always_comb
    begin
        shift     = 1'b0;
        load_en   = 1'b0;
        load_idx  = fill_reg[IDX_W-1:0];
        fill_next = fill_reg;
        acc       = 1'b0;
        vld       = 1'b0;
        if (accept)
        begin
            unique case (cmd.kind)
                KIND_ENQ:
                begin
                    if (!full)
                    begin
                        load_en   = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                        acc       = 1'b1;
                    end
                end
                KIND_FORCE:
                begin
                    acc     = 1'b1;
                    load_en = 1'b1;
                    if (full)
                    begin
                        // drop the head, append at the tail cell
                        shift    = 1'b1;
                        load_idx = IDX_W'(DEPTH - 1);
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                KIND_DEQ:
                begin
                    if (!empty)
                    begin
                        shift     = 1'b1;
                        vld       = 1'b1;
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                KIND_FLUSH:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ITEM_BITS-1:0] up;

        if (i < DEPTH - 1)
        begin : g_mid
            assign up = cell_word[i + 1];
        end
        else
        begin : g_tail
            assign up = cell_word[i];
        end

        rfo_cell #(
            .ITEM_BITS (ITEM_BITS)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .load     (load_en && (load_idx == IDX_W'(i))),
            .fresh    (fresh),
            .upstream (up),
            .word     (cell_word[i])
        );
    end

    always_comb
    begin
        result_next.accepted   = acc;
        result_next.out_valid  = vld;
        result_next.out_data   = vld ? DATA_BITS'(cell_word[0]) : '0;
        result_next.fill_count = COUNT_BITS'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    // hold the last result; only done marks a transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/rfo_checker.sv */
`timescale 1ns / 1ps

module rfo_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  rfo_pkg::rfo_cmd_t    cmd,
    input  logic                 done,
    input  rfo_pkg::rfo_result_t result
);

    import rfo_pkg::*;

    // exactly one result per accepted command, in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (done == $past(start && !busy)))
        else $error("result strobe does not match accepted command");

    a_valid_only_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_valid) |-> ($past(cmd.kind) == KIND_DEQ && !result.accepted))
        else $error("valid data on a non-dequeue result");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.out_valid) |-> (result.out_data == '0))
        else $error("nonzero data without valid");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.kind) == KIND_FLUSH) |-> (result.fill_count == '0 && !result.accepted))
        else $error("flush did not empty the queue");

    a_force_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.kind) == KIND_FORCE) |-> (result.accepted && result.fill_count != '0))
        else $error("forced transfer not taken");

endmodule

bind ring_fifo_with_overwrite rfo_checker u_rfo_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rfo_pkg::*;

    localparam int DEPTH      = 32;
    localparam int ITEM_BITS  = 16;
    localparam int N_RANDOM   = 1800;
    localparam int QUIET_MAX  = 1000;
    localparam int DRAIN_WAIT = 4;
    localparam int PRINT_MAX  = 20;
    localparam logic [DATA_BITS-1:0] ITEM_MASK =
        (ITEM_BITS >= DATA_BITS) ? {DATA_BITS{1'b1}} : DATA_BITS'((1 << ITEM_BITS) - 1);

    // One directed row; reps > 1 repeats the row with the item word counting up.
    typedef struct packed {
        rfo_kind_t   kind;
        logic [15:0] data;
        logic [5:0]  reps;
        logic        typed;
        rfo_result_t want;
    } cmd_row_t;

    localparam int N_ROWS = 18;
    localparam cmd_row_t DIRECTED [N_ROWS] = '{
        '{KIND_DEQ,   16'h0000, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd0}},
        '{KIND_FLUSH, 16'h0000, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd0}},
        '{KIND_ENQ,   16'hFFFF, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd1}},
        '{KIND_FORCE, 16'h0000, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd2}},
        '{KIND_DEQ,   16'h1234, 6'd1,  1'b1, '{1'b0, 1'b1, 16'hFFFF, 6'd1}},
        '{KIND_DEQ,   16'hFFFF, 6'd1,  1'b1, '{1'b0, 1'b1, 16'h0000, 6'd0}},
        '{KIND_DEQ,   16'h0000, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd0}},
        '{KIND_ENQ,   16'hA5A0, 6'd32, 1'b0, '0},
        '{KIND_ENQ,   16'h1234, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd32}},
        '{KIND_FORCE, 16'h5A5A, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd32}},
        '{KIND_FORCE, 16'hFFFF, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd32}},
        '{KIND_DEQ,   16'h0000, 6'd3,  1'b0, '0},
        '{KIND_ENQ,   16'h0001, 6'd3,  1'b0, '0},
        '{KIND_FLUSH, 16'hFFFF, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd0}},
        '{KIND_ENQ,   16'h8000, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd1}},
        '{KIND_FLUSH, 16'h0000, 6'd1,  1'b1, '{1'b0, 1'b0, 16'h0000, 6'd0}},
        '{KIND_FORCE, 16'h7FFF, 6'd1,  1'b1, '{1'b1, 1'b0, 16'h0000, 6'd1}},
        '{KIND_DEQ,   16'h0000, 6'd1,  1'b1, '{1'b0, 1'b1, 16'h7FFF, 6'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rfo_cmd_t    cmd;
    logic        done;
    rfo_result_t result;

    // Typed expectation travels alongside the command it belongs to.
    logic        cmd_typed;
    rfo_result_t cmd_want;

    logic [DATA_BITS-1:0] fifo_words [DEPTH];
    int          fifo_fill;
    int          fifo_rd;
    int          fifo_wr;

    rfo_result_t expected_results[$];
    int          n_errors;
    int          n_cmds;
    int          n_results;
    int          n_rejected;
    int          n_overwrites;
    int          n_empty_deq;
    int          n_flushes;
    int          quiet_cycles;
    int          sender_idle_pct;

    ring_fifo_with_overwrite #(
        .DEPTH     (DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rfo_result_t fifo_outcome(rfo_cmd_t c);
        rfo_result_t r;
        r = '0;
        case (c.kind)
            KIND_ENQ, KIND_FORCE:
            begin
                if (fifo_fill < DEPTH || c.kind == KIND_FORCE)
                begin
                    // Full forced write: drop the oldest, fill holds at DEPTH.
                    if (fifo_fill == DEPTH)
                    begin
                        fifo_rd = (fifo_rd + 1) % DEPTH;
                        n_overwrites++;
                    end
                    else
                        fifo_fill++;
                    fifo_words[fifo_wr] = c.item_data & ITEM_MASK;
                    fifo_wr = (fifo_wr + 1) % DEPTH;
                    r.accepted = 1'b1;
                end
                else
                    n_rejected++;
            end
            KIND_DEQ:
            begin
                if (fifo_fill != 0)
                begin
                    r.out_valid = 1'b1;
                    r.out_data  = fifo_words[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % DEPTH;
                    fifo_fill--;
                end
                else
                    n_empty_deq++;
            end
            default:
            begin
                fifo_fill = 0;
                fifo_rd   = 0;
                fifo_wr   = 0;
                n_flushes++;
            end
        endcase
        r.fill_count = COUNT_BITS'(fifo_fill);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= PRINT_MAX)
            $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, n_results, what, got, want);
    endtask

    always @(posedge clk)
    begin : monitor
        rfo_result_t want;
        rfo_result_t predicted;
        logic        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                predicted = fifo_outcome(cmd);
                expected_results.push_back(cmd_typed ? cmd_want : predicted);
                n_cmds++;
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transfer", 32'(result), 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(result.accepted),
                                        32'(want.accepted));
                    if (result.out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(result.out_valid),
                                        32'(want.out_valid));
                    if (result.out_data !== want.out_data)
                        report_mismatch("out_data", 32'(result.out_data),
                                        32'(want.out_data));
                    if (result.fill_count !== want.fill_count)
                        report_mismatch("fill_count", 32'(result.fill_count),
                                        32'(want.fill_count));
                end
                n_results++;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_MAX);
        $display("watchdog: no transfer for %0d cycles", QUIET_MAX);
        $display("** ring_fifo_with_overwrite: FAILED **");
        $finish;
    end

    task automatic send_cmd(input rfo_kind_t kind, input logic [15:0] data,
                            input logic typed, input rfo_result_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            cmd   <= rfo_cmd_t'($urandom);
            @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= '{kind: kind, item_data: data};
        cmd_typed <= typed;
        cmd_want  <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int          left;
        int          run;
        int          mode;
        int          r;
        int          t_enq;
        int          t_force;
        int          t_deq;
        rfo_kind_t   kind;
        logic [15:0] data;
        left = count;
        while (left > 0)
        begin
            // Pick fill-heavy, drain-heavy or balanced stretches at random so the
            // queue swings between empty and full.
            mode = $urandom_range(2);
            run  = $urandom_range(60, 20);
            case (mode)
                0:       begin t_enq = 45; t_force = 80; t_deq = 97; end
                1:       begin t_enq = 15; t_force = 25; t_deq = 98; end
                default: begin t_enq = 25; t_force = 50; t_deq = 95; end
            endcase
            for (int i = 0; i < run && left > 0; i++)
            begin
                r = $urandom_range(99);
                if (r < t_enq)
                    kind = KIND_ENQ;
                else if (r < t_force)
                    kind = KIND_FORCE;
                else if (r < t_deq)
                    kind = KIND_DEQ;
                else
                    kind = KIND_FLUSH;
                case ($urandom_range(7))
                    0:       data = 16'h0000;
                    1:       data = 16'hFFFF;
                    default: data = 16'($urandom);
                endcase
                send_cmd(kind, data, 1'b0, '0);
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = '0;
        cmd_typed       = 1'b0;
        cmd_want        = '0;
        fifo_fill       = 0;
        fifo_rd         = 0;
        fifo_wr         = 0;
        n_errors        = 0;
        n_cmds          = 0;
        n_results       = 0;
        n_rejected      = 0;
        n_overwrites    = 0;
        n_empty_deq     = 0;
        n_flushes       = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 28;
        for (int i = 0; i < DEPTH; i++)
            fifo_words[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            for (int k = 0; k < DIRECTED[i].reps; k++)
                send_cmd(DIRECTED[i].kind, DIRECTED[i].data + 16'(k),
                         DIRECTED[i].typed, DIRECTED[i].want);

        send_random(N_RANDOM / 3);
        sender_idle_pct = 74;
        send_random(N_RANDOM / 3);
        sender_idle_pct = 0;
        send_random(N_RANDOM - 2 * (N_RANDOM / 3));
        start <= 1'b0;

        // Hold until every expected transfer is back, then let the pipe drain.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d commands, checked %0d results, %0d mismatches",
                 n_cmds, n_results, n_errors);
        $display("full rejects %0d, overwrites %0d, empty dequeues %0d, flushes %0d",
                 n_rejected, n_overwrites, n_empty_deq, n_flushes);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("** ring_fifo_with_overwrite: PASSED **");
        else
            $display("** ring_fifo_with_overwrite: FAILED **");
        $finish;
    end

endmodule
